// File: rtl/core/vmb_pkg.sv
// Shared types, codes and trig tables for the vertex morph blend block.
package vmb_pkg;

    typedef logic signed [15:0] s16_t;

    // One store entry: lanes 0..2 position x,y,z (Q10.6), lanes 3..5 normal x,y,z (Q1.14).
    typedef logic [5:0][15:0] entry_t;

    localparam entry_t ZERO_ENTRY = {16'd0, 16'd16384, 16'd0, 16'd0, 16'd0, 16'd0};

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [2:0] REG_FRAME_COUNT = 3'd0;
    localparam logic [2:0] REG_VERTEX_COUNT = 3'd1;
    localparam logic [2:0] REG_CUR_FRAMES = 3'd2;
    localparam logic [2:0] REG_PREV_FRAMES = 3'd3;
    localparam logic [2:0] REG_CUR_WEIGHT = 3'd4;
    localparam logic [2:0] REG_PREV_WEIGHT = 3'd5;
    localparam logic [2:0] REG_BLEND_WEIGHT = 3'd6;
    localparam logic [2:0] REG_BLEND_EN = 3'd7;

    localparam logic [16:0] W_ONE = 17'd65536;

    typedef enum logic [1:0] {SLOT_CA, SLOT_CB, SLOT_PA, SLOT_PB} slot_t;

    typedef enum logic [2:0] {
        SQ_IDLE, SQ_RD0, SQ_RD1, SQ_RD2, SQ_RD3, SQ_LD0, SQ_LD1, SQ_LD2
    } sq_state_t;

    typedef enum logic [2:0] {NM_IDLE, NM_SQRT, NM_DINIT, NM_DIV, NM_DONE} nm_state_t;

    typedef logic signed [15:0] trig_tbl_t [256];

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // Q30 Taylor series on a reduced angle, rounded to Q1.14
    function automatic s16_t series_q14(input logic [63:0] x, input bit want_sin);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] tt;
        longint sum;
        x2 = (x * x) >> 30;
        t = want_sin ? x : (64'd1 << 30);
        sum = longint'(t);
        for (int n = 1; n <= 7; n++) begin
            tt = (t * x2) >> 30;
            case (n)
                1: t = want_sin ? tt / 6 : tt / 2;
                2: t = want_sin ? tt / 20 : tt / 12;
                3: t = want_sin ? tt / 42 : tt / 30;
                4: t = want_sin ? tt / 72 : tt / 56;
                5: t = want_sin ? tt / 110 : tt / 90;
                6: t = want_sin ? tt / 156 : tt / 132;
                default: t = want_sin ? tt / 210 : tt / 182;
            endcase
            if ((n % 2) == 1)
                sum = sum - longint'(t);
            else
                sum = sum + longint'(t);
        end
        if (sum < 0)
            sum = 0;
        return s16_t'((sum + 32768) >>> 16);
    endfunction

    function automatic trig_tbl_t build_trig(input bit want_sin);
        trig_tbl_t tbl;
        logic [63:0] k4;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] x;
        s16_t sv;
        s16_t cv;
        for (int k = 0; k < 256; k++) begin
            k4 = 64'(4 * k);
            q = (k4 / 255) & 64'd3;
            r = k4 % 255;
            x = (r * PI_Q30 + 64'd255) / 510;
            sv = series_q14(x, 1'b1);
            cv = series_q14(x, 1'b0);
            case (q)
                64'd0: tbl[k] = want_sin ? sv : cv;
                64'd1: tbl[k] = want_sin ? cv : -sv;
                64'd2: tbl[k] = want_sin ? -sv : -cv;
                default: tbl[k] = want_sin ? -cv : sv;
            endcase
        end
        return tbl;
    endfunction

    localparam trig_tbl_t SIN_TBL = build_trig(1'b1);
    localparam trig_tbl_t COS_TBL = build_trig(1'b0);

endpackage

// File: rtl/core/vmb_ram.sv
// Generic single-port RAM with registered read.
module vmb_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 65536,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_q [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem_q[addr] <= wdata;
        else if (re)
            rdata <= mem_q[addr];
    end

endmodule

// File: rtl/core/vmb_norm.sv
// Iterative normal renormalizer: integer square root, then three restoring dividers.
module vmb_norm (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  vmb_pkg::s16_t       n_in [3],
    input  logic [31:0]         sq_in [3],
    output logic                out_valid,
    input  logic                out_ready,
    output vmb_pkg::s16_t       n_out [3],
    output logic                fallback
);

    vmb_pkg::nm_state_t state_reg, state_next;

    logic [47:0] v_reg, res_reg, bit_reg;
    logic [15:0] mag_reg [3];
    logic        neg_reg [3];
    logic [24:0] rem_reg [3];
    logic [14:0] nlow_reg [3];
    logic [14:0] q_reg [3];
    logic [2:0]  dcnt_reg;
    logic        fb_reg;

    logic [31:0] len2;
    logic [47:0] v1, r1, v2, r2, bit2;
    logic [24:0] dvs;
    logic [39:0] num [3];
    logic [25:0] rw [3][4];
    logic [2:0]  qb [3];

    assign len2 = sq_in[0] + sq_in[1] + sq_in[2];

    // two square-root steps per cycle
    always_comb
    begin
        bit2 = bit_reg >> 2;
        if (v_reg >= res_reg + bit_reg)
        begin
            v1 = v_reg - (res_reg + bit_reg);
            r1 = (res_reg >> 1) + bit_reg;
        end
        else
        begin
            v1 = v_reg;
            r1 = res_reg >> 1;
        end
        if (v1 >= r1 + bit2)
        begin
            v2 = v1 - (r1 + bit2);
            r2 = (r1 >> 1) + bit2;
        end
        else
        begin
            v2 = v1;
            r2 = r1 >> 1;
        end
    end

    // three quotient bits per lane per cycle
    assign dvs = {res_reg[23:0], 1'b0};
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num[i] = {1'b0, mag_reg[i], 23'd0} + 40'(res_reg[23:0]);
            rw[i][0] = {1'b0, rem_reg[i]};
            for (int j = 0; j < 3; j++)
            begin
                rw[i][j+1] = {rw[i][j][24:0], nlow_reg[i][14-j]};
                if (rw[i][j+1] >= {1'b0, dvs})
                begin
                    rw[i][j+1] = rw[i][j+1] - {1'b0, dvs};
                    qb[i][2-j] = 1'b1;
                end
                else
                begin
                    qb[i][2-j] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vmb_pkg::NM_IDLE:
                if (in_valid)
                    state_next = (len2 == 32'd0) ? vmb_pkg::NM_DONE : vmb_pkg::NM_SQRT;
            vmb_pkg::NM_SQRT:
                if (bit_reg == 48'd4)
                    state_next = vmb_pkg::NM_DINIT;
            vmb_pkg::NM_DINIT:
                state_next = vmb_pkg::NM_DIV;
            vmb_pkg::NM_DIV:
                if (dcnt_reg == 3'd4)
                    state_next = vmb_pkg::NM_DONE;
            vmb_pkg::NM_DONE:
                if (out_ready)
                    state_next = vmb_pkg::NM_IDLE;
            default:
                state_next = vmb_pkg::NM_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == vmb_pkg::NM_IDLE);
        out_valid = (state_reg == vmb_pkg::NM_DONE);
        fallback = fb_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (fb_reg)
                n_out[i] = (i == 1) ? 16'sd16384 : 16'sd0;
            else if (neg_reg[i])
                n_out[i] = -$signed({1'b0, q_reg[i]});
            else
                n_out[i] = $signed({1'b0, q_reg[i]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= vmb_pkg::NM_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            vmb_pkg::NM_IDLE:
                if (in_valid)
                begin
                    v_reg <= {len2, 16'd0};
                    res_reg <= 48'd0;
                    bit_reg <= 48'd1 << 46;
                    fb_reg <= (len2 == 32'd0);
                    for (int i = 0; i < 3; i++)
                    begin
                        neg_reg[i] <= n_in[i][15];
                        mag_reg[i] <= n_in[i][15] ? 16'(-n_in[i]) : 16'(n_in[i]);
                    end
                end
            vmb_pkg::NM_SQRT:
            begin
                v_reg <= v2;
                res_reg <= r2;
                bit_reg <= bit_reg >> 4;
            end
            vmb_pkg::NM_DINIT:
            begin
                dcnt_reg <= 3'd0;
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[i] <= num[i][39:15];
                    nlow_reg[i] <= num[i][14:0];
                    q_reg[i] <= 15'd0;
                end
            end
            vmb_pkg::NM_DIV:
            begin
                dcnt_reg <= dcnt_reg + 3'd1;
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[i] <= rw[i][3][24:0];
                    nlow_reg[i] <= {nlow_reg[i][11:0], 3'd0};
                    q_reg[i] <= {q_reg[i][11:0], qb[i]};
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: rtl/core/vertex_morph_blend.sv
// Vertex morph blend: frame store with per-vertex interpolation, pose blend and renormalize.
// Load words (tuser 0) decode a lat/long normal through sine and cosine tables and
// write one in-range (frame, vertex) entry of the single-port frame store; a load
// occupies the sequencer states LD0, LD1 and LD2 and gives no result. Evaluate words
// (tuser 1) read four entries (current pair, previous pair) from that store, one per
// cycle unless the last read waits for the job register to free. Reads flow into a 5-stage
// interpolate/blend/square pipeline and then into the renormalizer: a 2-bit-per-cycle
// square root and three 3-bit-per-cycle dividers, which takes one normal at a time
// and so sets the sustained evaluate rate; front end and pipeline overlap with it.
// Zero-length normals return (0,1,0) with tuser set. Configuration must be written
// only while the block is idle.
// The store has no reset; reading an entry that was never loaded gives garbage.
module vertex_morph_blend #(
    parameter int MAX_FRAMES = 64,
    parameter int MAX_VERTS = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // frame_index[5:0], vertex_index[15:6], raw_x[31:16], raw_y[47:32], raw_z[63:48],
    // latitude[71:64], longitude[79:72]
    input  logic [79:0]  s_tdata,
    // opcode[0]
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_vertex[9:0], out_x[25:10], out_y[41:26], out_z[57:42], normal_x[73:58],
    // normal_y[89:74], normal_z[105:90], zero pad[111:106]
    output logic [111:0] m_tdata,
    // normal_fallback[0]
    output logic         m_tuser,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [16:0]  cfg_wdata
);

    localparam int DEPTH = MAX_FRAMES * MAX_VERTS;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(MAX_FRAMES + MAX_VERTS + 2048);

    // ---------------- configuration registers
    logic [6:0]  frame_count_reg;
    logic [10:0] vertex_count_reg;
    logic [11:0] cur_frames_reg, prev_frames_reg;
    logic [16:0] cur_weight_reg, prev_weight_reg, blend_weight_reg;
    logic        blend_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= 7'd1;
            vertex_count_reg <= 11'd1;
            cur_frames_reg <= 12'd0;
            prev_frames_reg <= 12'd0;
            cur_weight_reg <= 17'd0;
            prev_weight_reg <= 17'd0;
            blend_weight_reg <= 17'd0;
            blend_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                vmb_pkg::REG_FRAME_COUNT:  frame_count_reg <= cfg_wdata[6:0];
                vmb_pkg::REG_VERTEX_COUNT: vertex_count_reg <= cfg_wdata[10:0];
                vmb_pkg::REG_CUR_FRAMES:   cur_frames_reg <= cfg_wdata[11:0];
                vmb_pkg::REG_PREV_FRAMES:  prev_frames_reg <= cfg_wdata[11:0];
                vmb_pkg::REG_CUR_WEIGHT:   cur_weight_reg <= cfg_wdata;
                vmb_pkg::REG_PREV_WEIGHT:  prev_weight_reg <= cfg_wdata;
                vmb_pkg::REG_BLEND_WEIGHT: blend_weight_reg <= cfg_wdata;
                vmb_pkg::REG_BLEND_EN:     blend_en_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // saturated weights; blend off folds into a zero weight
    logic [16:0] tc, tp, tb;
    assign tc = (cur_weight_reg > vmb_pkg::W_ONE) ? vmb_pkg::W_ONE : cur_weight_reg;
    assign tp = (prev_weight_reg > vmb_pkg::W_ONE) ? vmb_pkg::W_ONE : prev_weight_reg;
    assign tb = !blend_en_reg ? 17'd0 :
                (blend_weight_reg > vmb_pkg::W_ONE) ? vmb_pkg::W_ONE : blend_weight_reg;

    // effective clamp limits
    logic [CW-1:0] lf, lv;
    logic          zero_cnt;
    assign lf = (CW'(frame_count_reg) < CW'(MAX_FRAMES)) ? CW'(frame_count_reg)
                                                         : CW'(MAX_FRAMES);
    assign lv = (CW'(vertex_count_reg) < CW'(MAX_VERTS)) ? CW'(vertex_count_reg)
                                                         : CW'(MAX_VERTS);
    assign zero_cnt = (lf == '0) || (lv == '0);

    // ---------------- input holding register
    logic        hold_valid_reg;
    logic        hold_op_reg;
    logic [79:0] hold_data_reg;
    logic        take;

    assign s_tready = !hold_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            hold_valid_reg <= 1'b1;
        else if (take)
            hold_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            hold_op_reg <= s_tuser;
            hold_data_reg <= s_tdata;
        end
    end

    // ---------------- sequencer: owns the store port
    vmb_pkg::sq_state_t sq_reg, sq_next;
    logic [79:0] it_data_reg;
    logic        j_valid_reg;
    logic        rdy1;
    logic        rd3_go;
    logic        mem_re, mem_we;
    vmb_pkg::slot_t rd_slot;
    logic [AW-1:0]  mem_addr;
    vmb_pkg::entry_t mem_wdata, mem_rdata;

    logic [5:0]    it_frame;
    logic [9:0]    it_vert;
    logic [5:0]    fsel;
    logic [CW-1:0] fcl, vcl;
    logic          ld_ok;

    assign it_frame = it_data_reg[5:0];
    assign it_vert = it_data_reg[15:6];
    assign rd3_go = !j_valid_reg || rdy1;

    always_comb
    begin
        sq_next = sq_reg;
        unique case (sq_reg)
            vmb_pkg::SQ_IDLE:
                if (hold_valid_reg)
                    sq_next = (hold_op_reg == vmb_pkg::OP_EVAL) ? vmb_pkg::SQ_RD0
                                                                : vmb_pkg::SQ_LD0;
            vmb_pkg::SQ_RD0: sq_next = vmb_pkg::SQ_RD1;
            vmb_pkg::SQ_RD1: sq_next = vmb_pkg::SQ_RD2;
            vmb_pkg::SQ_RD2: sq_next = vmb_pkg::SQ_RD3;
            vmb_pkg::SQ_RD3:
                if (rd3_go)
                begin
                    if (hold_valid_reg)
                        sq_next = (hold_op_reg == vmb_pkg::OP_EVAL) ? vmb_pkg::SQ_RD0
                                                                    : vmb_pkg::SQ_LD0;
                    else
                        sq_next = vmb_pkg::SQ_IDLE;
                end
            vmb_pkg::SQ_LD0: sq_next = vmb_pkg::SQ_LD1;
            vmb_pkg::SQ_LD1: sq_next = vmb_pkg::SQ_LD2;
            vmb_pkg::SQ_LD2:
                if (hold_valid_reg)
                    sq_next = (hold_op_reg == vmb_pkg::OP_EVAL) ? vmb_pkg::SQ_RD0
                                                                : vmb_pkg::SQ_LD0;
                else
                    sq_next = vmb_pkg::SQ_IDLE;
            default: sq_next = vmb_pkg::SQ_IDLE;
        endcase
    end

    assign ld_ok = (CW'(it_frame) < CW'(MAX_FRAMES)) && (CW'(it_vert) < CW'(MAX_VERTS));

    always_comb
    begin
        take = 1'b0;
        mem_re = 1'b0;
        mem_we = 1'b0;
        rd_slot = vmb_pkg::SLOT_CA;
        unique case (sq_reg)
            vmb_pkg::SQ_IDLE: take = hold_valid_reg;
            vmb_pkg::SQ_RD0:
            begin
                mem_re = 1'b1;
                rd_slot = vmb_pkg::SLOT_CA;
            end
            vmb_pkg::SQ_RD1:
            begin
                mem_re = 1'b1;
                rd_slot = vmb_pkg::SLOT_CB;
            end
            vmb_pkg::SQ_RD2:
            begin
                mem_re = 1'b1;
                rd_slot = vmb_pkg::SLOT_PA;
            end
            vmb_pkg::SQ_RD3:
            begin
                mem_re = rd3_go;
                rd_slot = vmb_pkg::SLOT_PB;
                take = rd3_go && hold_valid_reg;
            end
            vmb_pkg::SQ_LD2:
            begin
                mem_we = ld_ok;
                take = hold_valid_reg;
            end
            default: ;
        endcase
    end

    // clamped read address
    always_comb
    begin
        unique case (rd_slot)
            vmb_pkg::SLOT_CA: fsel = cur_frames_reg[5:0];
            vmb_pkg::SLOT_CB: fsel = cur_frames_reg[11:6];
            vmb_pkg::SLOT_PA: fsel = prev_frames_reg[5:0];
            vmb_pkg::SLOT_PB: fsel = prev_frames_reg[11:6];
            default: fsel = 6'd0;
        endcase
        fcl = (CW'(fsel) > CW'(lf - CW'(1))) ? CW'(lf - CW'(1)) : CW'(fsel);
        vcl = (CW'(it_vert) > CW'(lv - CW'(1))) ? CW'(lv - CW'(1)) : CW'(it_vert);
        if (mem_we)
            mem_addr = AW'(it_frame) * AW'(MAX_VERTS) + AW'(it_vert);
        else
            mem_addr = AW'(fcl) * AW'(MAX_VERTS) + AW'(vcl);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_reg <= vmb_pkg::SQ_IDLE;
        else
            sq_reg <= sq_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            it_data_reg <= hold_data_reg;
    end

    // ---------------- load decode: table lookup, then products
    vmb_pkg::s16_t sla_reg, cla_reg, sln_reg, cln_reg, ldx_reg, ldy_reg;
    logic signed [31:0] px_prod, py_prod;

    assign px_prod = (32'(cla_reg) * 32'(sln_reg) + 32'sd8192) >>> 14;
    assign py_prod = (32'(sla_reg) * 32'(sln_reg) + 32'sd8192) >>> 14;

    always_ff @(posedge clk)
    begin
        if (sq_reg == vmb_pkg::SQ_LD0)
        begin
            sla_reg <= vmb_pkg::SIN_TBL[it_data_reg[71:64]];
            cla_reg <= vmb_pkg::COS_TBL[it_data_reg[71:64]];
            sln_reg <= vmb_pkg::SIN_TBL[it_data_reg[79:72]];
            cln_reg <= vmb_pkg::COS_TBL[it_data_reg[79:72]];
        end
        if (sq_reg == vmb_pkg::SQ_LD1)
        begin
            ldx_reg <= px_prod[15:0];
            ldy_reg <= py_prod[15:0];
        end
    end

    assign mem_wdata = {cln_reg, ldy_reg, ldx_reg,
                        it_data_reg[63:48], it_data_reg[47:32], it_data_reg[31:16]};

    vmb_ram #(
        .WIDTH(96),
        .DEPTH(DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // ---------------- read capture
    logic            cap_vld_reg;
    vmb_pkg::slot_t  cap_slot_reg;
    logic [9:0]      cap_ov_reg;
    vmb_pkg::entry_t cap_entry;
    vmb_pkg::entry_t e0_reg, e1_reg, e2_reg;
    vmb_pkg::entry_t j0_reg, j1_reg, j2_reg, j3_reg;
    logic [9:0]      j_ov_reg;
    logic            cap3;

    assign cap_entry = zero_cnt ? vmb_pkg::ZERO_ENTRY : mem_rdata;
    assign cap3 = cap_vld_reg && (cap_slot_reg == vmb_pkg::SLOT_PB);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_vld_reg <= 1'b0;
            j_valid_reg <= 1'b0;
        end
        else
        begin
            cap_vld_reg <= mem_re;
            if (cap3)
                j_valid_reg <= 1'b1;
            else if (j_valid_reg && rdy1)
                j_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cap_slot_reg <= rd_slot;
        if (sq_reg == vmb_pkg::SQ_RD3)
            cap_ov_reg <= zero_cnt ? 10'd0 : vcl[9:0];
        if (cap_vld_reg)
        begin
            unique case (cap_slot_reg)
                vmb_pkg::SLOT_CA: e0_reg <= cap_entry;
                vmb_pkg::SLOT_CB: e1_reg <= cap_entry;
                vmb_pkg::SLOT_PA: e2_reg <= cap_entry;
                vmb_pkg::SLOT_PB:
                begin
                    j0_reg <= e0_reg;
                    j1_reg <= e1_reg;
                    j2_reg <= e2_reg;
                    j3_reg <= cap_entry;
                    j_ov_reg <= cap_ov_reg;
                end
                default: ;
            endcase
        end
    end

    // ---------------- interpolate / blend / square pipeline
    function automatic logic signed [34:0] wmul(input logic [15:0] a, input logic [15:0] b,
                                                input logic [16:0] t);
        logic signed [16:0] d;
        d = $signed({b[15], b}) - $signed({a[15], a});
        return d * $signed({1'b0, t});
    endfunction

    function automatic vmb_pkg::s16_t rnd_add(input logic [15:0] a,
                                              input logic signed [34:0] pr);
        logic signed [34:0] s;
        s = (pr + 35'sd32768) >>> 16;
        return a + s[15:0];
    endfunction

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy2, rdy3, rdy4, rdy5;
    logic nm_in_ready;

    logic [15:0]        ac1_reg [6], ap1_reg [6];
    logic signed [34:0] pc1_reg [6], pp1_reg [6];
    logic [15:0]        c2_reg [6], q2_reg [6];
    logic [15:0]        b3_reg [6];
    logic signed [34:0] pb3_reg [6];
    vmb_pkg::s16_t      r4_reg [6];
    vmb_pkg::s16_t      n5_reg [3], p5_reg [3];
    logic [31:0]        sq5_reg [3];
    logic [9:0]         ov1_reg, ov2_reg, ov3_reg, ov4_reg, ov5_reg;

    assign rdy5 = !v5_reg || nm_in_ready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= j_valid_reg;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            ov1_reg <= j_ov_reg;
            for (int i = 0; i < 6; i++)
            begin
                ac1_reg[i] <= j0_reg[i];
                pc1_reg[i] <= wmul(j0_reg[i], j1_reg[i], tc);
                ap1_reg[i] <= j2_reg[i];
                pp1_reg[i] <= wmul(j2_reg[i], j3_reg[i], tp);
            end
        end
        if (rdy2)
        begin
            ov2_reg <= ov1_reg;
            for (int i = 0; i < 6; i++)
            begin
                c2_reg[i] <= rnd_add(ac1_reg[i], pc1_reg[i]);
                q2_reg[i] <= rnd_add(ap1_reg[i], pp1_reg[i]);
            end
        end
        if (rdy3)
        begin
            ov3_reg <= ov2_reg;
            for (int i = 0; i < 6; i++)
            begin
                b3_reg[i] <= c2_reg[i];
                pb3_reg[i] <= wmul(c2_reg[i], q2_reg[i], tb);
            end
        end
        if (rdy4)
        begin
            ov4_reg <= ov3_reg;
            for (int i = 0; i < 6; i++)
                r4_reg[i] <= rnd_add(b3_reg[i], pb3_reg[i]);
        end
        if (rdy5)
        begin
            ov5_reg <= ov4_reg;
            for (int i = 0; i < 3; i++)
            begin
                p5_reg[i] <= r4_reg[i];
                n5_reg[i] <= r4_reg[3+i];
                sq5_reg[i] <= 32'(32'(r4_reg[3+i]) * 32'(r4_reg[3+i]));
            end
        end
    end

    // ---------------- renormalize
    logic          nm_out_valid, nm_out_ready, nm_fb;
    vmb_pkg::s16_t nm_n [3];
    vmb_pkg::s16_t nm_pos_reg [3];
    logic [9:0]    nm_ov_reg;

    vmb_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .in_ready  (nm_in_ready),
        .n_in      (n5_reg),
        .sq_in     (sq5_reg),
        .out_valid (nm_out_valid),
        .out_ready (nm_out_ready),
        .n_out     (nm_n),
        .fallback  (nm_fb)
    );

    always_ff @(posedge clk)
    begin
        if (v5_reg && nm_in_ready)
        begin
            nm_ov_reg <= ov5_reg;
            for (int i = 0; i < 3; i++)
                nm_pos_reg[i] <= p5_reg[i];
        end
    end

    // ---------------- output register
    logic         m_tvalid_reg;
    logic [111:0] m_tdata_reg;
    logic         m_tuser_reg;

    assign nm_out_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (nm_out_ready)
            m_tvalid_reg <= nm_out_valid;
    end

    always_ff @(posedge clk)
    begin
        if (nm_out_valid && nm_out_ready)
        begin
            m_tdata_reg <= {6'd0, nm_n[2], nm_n[1], nm_n[0],
                            nm_pos_reg[2], nm_pos_reg[1], nm_pos_reg[0], nm_ov_reg};
            m_tuser_reg <= nm_fb;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

    // ---------------- checks
    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("store read and write in one cycle");

    a_job_free: assert property (@(posedge clk) disable iff (!rst_n)
        cap3 |-> !j_valid_reg)
        else $error("last read captured while job register full");

    a_fallback: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[89:74] == 16'd16384 && m_tdata[73:58] == 16'd0))
        else $error("fallback word without unit y normal");

endmodule
